// ----- rtl/psd_pkg.sv -----
// Shared types and constants for the point-to-segment distance unit.
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int NEAR_W     = 24;
  localparam int DIST_W     = 52;
  localparam int DIR_W      = COORD_BITS + 1;
  localparam int DEN_W      = 2 * COORD_BITS + 2;
  localparam int DOT_W      = 2 * DIR_W + 2;

  localparam logic [1:0] REGION_START = 2'd0;
  localparam logic [1:0] REGION_END   = 2'd1;
  localparam logic [1:0] REGION_INNER = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]      dir_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } in_word_t;

  typedef struct packed {
    logic signed [NEAR_W-1:0] near_x;
    logic signed [NEAR_W-1:0] near_y;
    logic signed [NEAR_W-1:0] near_z;
    logic [DIST_W-1:0]        dist_squared;
    logic [1:0]               region;
  } out_word_t;

  typedef struct packed {
    coord_t [2:0]      s;
    coord_t [2:0]      e;
    coord_t [2:0]      q;
    dir_t [2:0]        dir;
    logic [DEN_W-1:0]  t_start;
    logic [DEN_W-1:0]  den;
    logic [1:0]        region;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- rtl/psd_front.sv -----
// Front pipeline: direction vectors, dot products and region classification.
module psd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psd_pkg::in_word_t  in_word,
  input  psd_pkg::fifo_stat_t stat,
  output logic               push,
  output psd_pkg::item_t     item
);

  localparam int DW  = psd_pkg::DIR_W;
  localparam int PW  = 2 * psd_pkg::DIR_W;
  localparam int TW  = psd_pkg::DOT_W;

  logic en;
  logic v1_r, v2_r, v3_r;

  psd_pkg::coord_t s_c [3];
  psd_pkg::coord_t e_c [3];
  psd_pkg::coord_t q_c [3];

  psd_pkg::coord_t s1_r [3];
  psd_pkg::coord_t e1_r [3];
  psd_pkg::coord_t q1_r [3];
  psd_pkg::dir_t   dir1_r [3];
  psd_pkg::dir_t   dqe1_r [3];
  psd_pkg::dir_t   dqs1_r [3];

  psd_pkg::coord_t s2_r [3];
  psd_pkg::coord_t e2_r [3];
  psd_pkg::coord_t q2_r [3];
  psd_pkg::dir_t   dir2_r [3];
  logic signed [PW-1:0] pe2_r [3];
  logic signed [PW-1:0] ps2_r [3];
  logic signed [PW-1:0] pd2_r [3];

  psd_pkg::coord_t s3_r [3];
  psd_pkg::coord_t e3_r [3];
  psd_pkg::coord_t q3_r [3];
  psd_pkg::dir_t   dir3_r [3];
  logic signed [TW-1:0] tend3_r, tstart3_r, den3_r;
  logic signed [TW-1:0] tend_nxt, tstart_nxt, den_nxt;

  // The whole front advances together unless the last stage is blocked by a full queue.
  assign en       = !(v3_r && stat.full);
  assign in_stall = !en;
  assign push     = v3_r && !stat.full;

  always_comb begin
    s_c[0] = in_word.start_x; s_c[1] = in_word.start_y; s_c[2] = in_word.start_z;
    e_c[0] = in_word.end_x;   e_c[1] = in_word.end_y;   e_c[2] = in_word.end_z;
    q_c[0] = in_word.query_x; q_c[1] = in_word.query_y; q_c[2] = in_word.query_z;
  end

  always_comb begin
    tend_nxt   = '0;
    tstart_nxt = '0;
    den_nxt    = '0;
    for (int i = 0; i < 3; i++) begin
      tend_nxt   = tend_nxt + TW'(pe2_r[i]);
      tstart_nxt = tstart_nxt + TW'(ps2_r[i]);
      den_nxt    = den_nxt + TW'(pd2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_r[i]   <= s_c[i];
        e1_r[i]   <= e_c[i];
        q1_r[i]   <= q_c[i];
        dir1_r[i] <= DW'(e_c[i]) - DW'(s_c[i]);
        dqe1_r[i] <= DW'(q_c[i]) - DW'(e_c[i]);
        dqs1_r[i] <= DW'(q_c[i]) - DW'(s_c[i]);

        s2_r[i]   <= s1_r[i];
        e2_r[i]   <= e1_r[i];
        q2_r[i]   <= q1_r[i];
        dir2_r[i] <= dir1_r[i];
        pe2_r[i]  <= PW'(dir1_r[i]) * PW'(dqe1_r[i]);
        ps2_r[i]  <= PW'(dir1_r[i]) * PW'(dqs1_r[i]);
        pd2_r[i]  <= PW'(dir1_r[i]) * PW'(dir1_r[i]);

        s3_r[i]   <= s2_r[i];
        e3_r[i]   <= e2_r[i];
        q3_r[i]   <= q2_r[i];
        dir3_r[i] <= dir2_r[i];
      end
      tend3_r   <= tend_nxt;
      tstart3_r <= tstart_nxt;
      den3_r    <= den_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.s[i]   = s3_r[i];
      item.e[i]   = e3_r[i];
      item.q[i]   = q3_r[i];
      item.dir[i] = dir3_r[i];
    end
    item.t_start = tstart3_r[psd_pkg::DEN_W-1:0];
    item.den     = den3_r[psd_pkg::DEN_W-1:0];
    if (!tend3_r[TW-1]) begin
      item.region = psd_pkg::REGION_END;
    end else if (tstart3_r[TW-1] || tstart3_r == '0 || den3_r == '0) begin
      item.region = psd_pkg::REGION_START;
    end else begin
      item.region = psd_pkg::REGION_INNER;
    end
  end

endmodule

// ----- rtl/psd_fifo.sv -----
// Short queue of classified items between the front and back pipelines.
module psd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psd_pkg::item_t      wr_item,
  input  logic                pop,
  output psd_pkg::item_t      rd_item,
  output psd_pkg::fifo_stat_t stat
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  psd_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r;

  assign stat.full  = (count_r == (AW+1)'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

// ----- rtl/psd_back.sv -----
// Back pipeline: projection divide, closest point, squared distance and output register.
module psd_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psd_pkg::item_t      rd_item,
  input  psd_pkg::fifo_stat_t stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output psd_pkg::out_word_t  out_word
);

  localparam int CW   = psd_pkg::COORD_BITS;
  localparam int DW   = psd_pkg::DIR_W;
  localparam int NDW  = psd_pkg::DEN_W;
  localparam int QB   = CW + FRAC_BITS + 1;
  localparam int MW   = DW + NDW + FRAC_BITS;
  localparam int NW   = (CW + FRAC_BITS + 2 > psd_pkg::NEAR_W) ? CW + FRAC_BITS + 2
                                                               : psd_pkg::NEAR_W;
  localparam int DDW  = NW + 1;
  localparam int SQW  = 2 * DDW + 2;

  logic en;
  logic out_valid_r;
  psd_pkg::out_word_t out_word_r;

  // Multiply stage.
  logic           m_vld_r;
  psd_pkg::item_t m_item_r;
  logic [MW-1:0]  m_num_r [3];
  logic [DW-1:0]  mag_c [3];

  // Divide stages, one quotient bit each.
  logic           dv_vld_r  [QB];
  psd_pkg::item_t dv_item_r [QB];
  logic [NDW-1:0] dv_rem_r  [QB][3];
  logic [QB-1:0]  dv_low_r  [QB][3];
  logic [QB-1:0]  dv_quo_r  [QB][3];

  // Rounding and closest-point stage.
  logic                  r_vld_r;
  psd_pkg::item_t        r_item_r;
  logic signed [NW-1:0]  r_near_r [3];
  logic signed [NW-1:0]  near_nxt [3];

  // Square stage.
  logic                   sq_vld_r;
  logic [1:0]             sq_region_r;
  logic signed [NW-1:0]   sq_near_r [3];
  logic signed [2*DDW-1:0] sq_r [3];
  logic signed [DDW-1:0]  d_c [3];
  logic [SQW-1:0]         dist_c;

  assign en        = !(out_valid_r && out_stall);
  assign pop       = en && !stat.empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = rd_item.dir[i][DW-1] ? DW'(-$signed(rd_item.dir[i])) : rd_item.dir[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_item_r <= rd_item;
      for (int i = 0; i < 3; i++) begin
        m_num_r[i] <= (MW'(mag_c[i]) * MW'(rd_item.t_start)) << FRAC_BITS;
      end
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic           src_vld;
    psd_pkg::item_t src_item;
    logic [NDW-1:0] src_rem [3];
    logic [QB-1:0]  src_low [3];
    logic [QB-1:0]  src_quo [3];
    logic [NDW:0]   trial [3];
    logic [NDW-1:0] rem_nxt [3];
    logic [QB-1:0]  quo_nxt [3];

    if (k == 0) begin : g_first
      always_comb begin
        src_vld  = m_vld_r;
        src_item = m_item_r;
        for (int i = 0; i < 3; i++) begin
          src_rem[i] = m_num_r[i][MW-1:QB];
          src_low[i] = m_num_r[i][QB-1:0];
          src_quo[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        src_vld  = dv_vld_r[k-1];
        src_item = dv_item_r[k-1];
        for (int i = 0; i < 3; i++) begin
          src_rem[i] = dv_rem_r[k-1][i];
          src_low[i] = dv_low_r[k-1][i];
          src_quo[i] = dv_quo_r[k-1][i];
        end
      end
    end

    // Restoring step: bring down the next numerator bit and try the divisor.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {src_rem[i], src_low[i][QB-1]};
        if (trial[i] >= {1'b0, src_item.den}) begin
          rem_nxt[i] = NDW'(trial[i] - {1'b0, src_item.den});
          quo_nxt[i] = {src_quo[i][QB-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i][NDW-1:0];
          quo_nxt[i] = {src_quo[i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_item_r[k] <= src_item;
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k][i] <= rem_nxt[i];
          dv_low_r[k][i] <= {src_low[i][QB-2:0], 1'b0};
          dv_quo_r[k][i] <= quo_nxt[i];
        end
      end
    end
  end

  // Round half up on the magnitude, then apply the direction's sign.
  always_comb begin
    logic [QB-1:0]        corr;
    logic signed [NW-1:0] base;
    for (int i = 0; i < 3; i++) begin
      corr = dv_quo_r[QB-1][i] +
             QB'({dv_rem_r[QB-1][i], 1'b0} >= {1'b0, dv_item_r[QB-1].den});
      base = NW'($signed(dv_item_r[QB-1].s[i])) <<< FRAC_BITS;
      case (dv_item_r[QB-1].region)
        psd_pkg::REGION_END: begin
          near_nxt[i] = NW'($signed(dv_item_r[QB-1].e[i])) <<< FRAC_BITS;
        end
        psd_pkg::REGION_INNER: begin
          if (dv_item_r[QB-1].dir[i][DW-1]) begin
            near_nxt[i] = base - $signed(NW'(corr));
          end else begin
            near_nxt[i] = base + $signed(NW'(corr));
          end
        end
        default: begin
          near_nxt[i] = base;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = (DDW'($signed(r_item_r.q[i])) <<< FRAC_BITS) - DDW'(r_near_r[i]);
    end
    dist_c = SQW'($unsigned(sq_r[0])) + SQW'($unsigned(sq_r[1])) +
             SQW'($unsigned(sq_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r     <= 1'b0;
      sq_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      r_vld_r     <= dv_vld_r[QB-1];
      sq_vld_r    <= r_vld_r;
      out_valid_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_item_r    <= dv_item_r[QB-1];
      sq_region_r <= r_item_r.region;
      for (int i = 0; i < 3; i++) begin
        r_near_r[i]  <= near_nxt[i];
        sq_near_r[i] <= r_near_r[i];
        sq_r[i]      <= (2*DDW)'(d_c[i]) * (2*DDW)'(d_c[i]);
      end
      out_word_r.near_x       <= sq_near_r[0][psd_pkg::NEAR_W-1:0];
      out_word_r.near_y       <= sq_near_r[1][psd_pkg::NEAR_W-1:0];
      out_word_r.near_z       <= sq_near_r[2][psd_pkg::NEAR_W-1:0];
      out_word_r.dist_squared <= dist_c[psd_pkg::DIST_W-1:0];
      out_word_r.region       <= sq_region_r;
    end
  end

endmodule

// ----- rtl/point_segment_distance_sq_3d_unit.sv -----
// Top level of the point-to-segment closest point and squared distance unit.
//
// Each input word carries a 3D segment (start, end) and a query point as signed
// 16-bit integers. The unit returns the closest point of the segment in fixed
// point with FRAC_BITS fractional bits, the squared distance with twice as many
// fractional bits, and a region code: first endpoint, second endpoint or
// interior. A degenerate segment reports the second endpoint. The unit takes one
// word per clock cycle while in_stall is low and keeps no state between words.
// A word passes through the front pipeline (differences, products, sums and
// classification), a four-entry queue, and then the back pipeline, whose length
// is set by the restoring divider that produces one quotient bit per stage.
// The front and back halves stall independently, the queue absorbing short
// stalls on the result side while input words are still taken.
module point_segment_distance_sq_3d_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output psd_pkg::out_word_t out_word
);

  logic                push;
  logic                pop;
  psd_pkg::item_t      wr_item;
  psd_pkg::item_t      rd_item;
  psd_pkg::fifo_stat_t stat;

  // Front half: classifies each word against the segment's two endpoints.
  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .stat     (stat),
    .push     (push),
    .item     (wr_item)
  );

  // The queue decouples the two halves.
  psd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (stat)
  );

  // Back half: divides out interior projections and forms the distance.
  psd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_item   (rd_item),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
